@@ rtl/hrbe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP request body extractor package
// Shared codes, character constants, match helpers and the result type.
// ----------------------------------------------------------------------------
package hrbe_pkg;

  // Input opcodes.
  localparam logic [1:0] OP_DATA   = 2'd0;
  localparam logic [1:0] OP_OPEN   = 2'd1;
  localparam logic [1:0] OP_CLOSE  = 2'd2;
  localparam logic [1:0] OP_SENT   = 2'd3;

  // Parser phases.
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_REQUEST = 3'd1;
  localparam logic [2:0] PH_HEADERS = 3'd2;
  localparam logic [2:0] PH_BODY    = 3'd3;
  localparam logic [2:0] PH_RESPOND = 3'd4;
  localparam logic [2:0] PH_DONE    = 3'd5;

  // Method counter values from the last of the four collected bytes onwards.
  localparam logic [2:0] MC_LAST_BYTE = 3'd3;
  localparam logic [2:0] MC_SKIP_LINE = 3'd4;
  localparam logic [2:0] MC_HEADERS   = 3'd5;

  // Separator progress values of interest.
  localparam logic [2:0] SEP_CR1  = 3'd1;
  localparam logic [2:0] SEP_LF1  = 3'd2;
  localparam logic [2:0] SEP_FULL = 3'd4;

  localparam logic [4:0] PREFIX_LEN = 5'd16;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] DIGIT_BASE = 8'h30;

  localparam logic [7:0] CHAR_G = 8'h47;
  localparam logic [7:0] CHAR_E = 8'h45;
  localparam logic [7:0] CHAR_T = 8'h54;
  localparam logic [7:0] CHAR_P = 8'h50;
  localparam logic [7:0] CHAR_O = 8'h4F;
  localparam logic [7:0] CHAR_S = 8'h53;

  typedef struct packed {
    logic       lcd_write;
    logic [7:0] lcd_data;
    logic       screen_clear;
    logic       resp_pending;
    logic [2:0] parser_phase;
    logic [7:0] body_remaining;
  } result_t;

  // Character at a given place of "Content-Length: ".
  function automatic logic [7:0] prefix_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h43; // C
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6E; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6E; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2D; // -
      4'd8:    c = 8'h4C; // L
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6E; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      4'd14:   c = 8'h3A; // :
      default: c = 8'h20; // space
    endcase
    return c;
  endfunction

  // One step through CR LF CR LF; a mismatch drops back to the start.
  function automatic logic [2:0] sep_next(input logic [2:0] sep, input logic [7:0] b);
    logic [7:0] want;
    want = sep[0] ? CHAR_LF : CHAR_CR;
    if (sep < SEP_FULL && b == want) begin
      return sep + 3'd1;
    end
    return 3'd0;
  endfunction

endpackage
`default_nettype wire

@@ rtl/hrbe_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP request body extractor channels
// Valid/ready channels for request events and for parser results.
// ----------------------------------------------------------------------------
interface hrbe_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface hrbe_out_if;
  logic       valid;
  logic       ready;
  logic       lcd_write;
  logic [7:0] lcd_data;
  logic       screen_clear;
  logic       resp_pending;
  logic [2:0] parser_phase;
  logic [7:0] body_remaining;

  modport source (output valid, output lcd_write, output lcd_data, output screen_clear,
                  output resp_pending, output parser_phase, output body_remaining,
                  input ready);
  modport sink   (input valid, input lcd_write, input lcd_data, input screen_clear,
                  input resp_pending, input parser_phase, input body_remaining,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/hrbe_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP request body extractor parser core
// Holds the parser state and works out one result per accepted beat.
// ----------------------------------------------------------------------------
module hrbe_core #(
  parameter int LENGTH_BITS = 8
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  accept,
  input  wire  [1:0]           opcode,
  input  wire  [7:0]           data_byte,
  output hrbe_pkg::result_t    result
);

  logic [2:0]             phase_r, phase_nxt;
  logic [2:0]             mcount_r, mcount_nxt;
  logic [2:0]             sep_r, sep_nxt;
  logic [4:0]             pfx_r, pfx_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  // Only the first three method bytes are stored; the fourth is the current beat.
  logic [7:0]             mbytes_r [0:2];

  logic [2:0]             sep_adv;
  logic [7:0]             digit;
  logic [LENGTH_BITS-1:0] len_dec;
  logic                   is_get, is_post;
  logic                   wr, clr;
  logic [7:0]             shown;

  assign sep_adv = hrbe_pkg::sep_next(sep_r, data_byte);
  assign digit   = data_byte - hrbe_pkg::DIGIT_BASE;
  assign len_dec = len_r - LENGTH_BITS'(1);
  assign is_get  = mbytes_r[0] == hrbe_pkg::CHAR_G && mbytes_r[1] == hrbe_pkg::CHAR_E &&
                   mbytes_r[2] == hrbe_pkg::CHAR_T;
  assign is_post = mbytes_r[0] == hrbe_pkg::CHAR_P && mbytes_r[1] == hrbe_pkg::CHAR_O &&
                   mbytes_r[2] == hrbe_pkg::CHAR_S && data_byte == hrbe_pkg::CHAR_T;

  always_comb begin
    phase_nxt  = phase_r;
    mcount_nxt = mcount_r;
    sep_nxt    = sep_r;
    pfx_nxt    = pfx_r;
    len_nxt    = len_r;
    wr         = 1'b0;
    clr        = 1'b0;
    shown      = 8'd0;
    case (opcode)
      hrbe_pkg::OP_OPEN: begin
        if (phase_r == hrbe_pkg::PH_IDLE) begin
          phase_nxt  = hrbe_pkg::PH_REQUEST;
          mcount_nxt = 3'd0;
          sep_nxt    = 3'd0;
          pfx_nxt    = 5'd0;
          len_nxt    = '0;
        end
      end
      hrbe_pkg::OP_CLOSE: begin
        phase_nxt  = hrbe_pkg::PH_IDLE;
        mcount_nxt = 3'd0;
        sep_nxt    = 3'd0;
        pfx_nxt    = 5'd0;
        len_nxt    = '0;
      end
      hrbe_pkg::OP_SENT: begin
        if (phase_r == hrbe_pkg::PH_RESPOND) begin
          phase_nxt = hrbe_pkg::PH_DONE;
        end
      end
      default: begin
        unique case (phase_r)
          hrbe_pkg::PH_REQUEST: begin
            mcount_nxt = mcount_r + 3'd1;
            if (mcount_r == hrbe_pkg::MC_LAST_BYTE) begin
              if (is_get || is_post) begin
                len_nxt    = '0;
                sep_nxt    = 3'd0;
                pfx_nxt    = 5'd0;
                mcount_nxt = hrbe_pkg::MC_SKIP_LINE;
                phase_nxt  = hrbe_pkg::PH_HEADERS;
              end else begin
                phase_nxt  = hrbe_pkg::PH_RESPOND;
              end
            end
          end
          hrbe_pkg::PH_HEADERS: begin
            sep_nxt = sep_adv;
            if (mcount_r != hrbe_pkg::MC_HEADERS) begin
              if (sep_adv == hrbe_pkg::SEP_LF1) begin
                mcount_nxt = hrbe_pkg::MC_HEADERS;
                pfx_nxt    = 5'd0;
              end
            end else begin
              if (!pfx_r[4] && data_byte == hrbe_pkg::prefix_char(pfx_r[3:0])) begin
                pfx_nxt = pfx_r + 5'd1;
              end else if (pfx_r != hrbe_pkg::PREFIX_LEN) begin
                pfx_nxt = 5'd0;
              end else if (sep_r < hrbe_pkg::SEP_LF1 && data_byte != hrbe_pkg::CHAR_CR) begin
                len_nxt = (len_r << 3) + (len_r << 1) + LENGTH_BITS'(digit);
              end
              if (sep_adv == hrbe_pkg::SEP_CR1) begin
                pfx_nxt = 5'd0;
              end
              if (sep_adv == hrbe_pkg::SEP_FULL) begin
                clr       = 1'b1;
                phase_nxt = (len_nxt == '0) ? hrbe_pkg::PH_RESPOND : hrbe_pkg::PH_BODY;
              end
            end
          end
          hrbe_pkg::PH_BODY: begin
            wr      = 1'b1;
            shown   = data_byte;
            len_nxt = len_dec;
            if (len_dec == '0) begin
              phase_nxt = hrbe_pkg::PH_RESPOND;
            end
          end
          default: begin
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= hrbe_pkg::PH_IDLE;
      mcount_r <= 3'd0;
      sep_r    <= 3'd0;
      pfx_r    <= 5'd0;
      len_r    <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      mcount_r <= mcount_nxt;
      sep_r    <= sep_nxt;
      pfx_r    <= pfx_nxt;
      len_r    <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && opcode == hrbe_pkg::OP_DATA && phase_r == hrbe_pkg::PH_REQUEST &&
        mcount_r != hrbe_pkg::MC_LAST_BYTE) begin
      mbytes_r[mcount_r[1:0]] <= data_byte;
    end
  end

  always_comb begin
    result.lcd_write      = wr;
    result.lcd_data       = shown;
    result.screen_clear   = clr;
    result.resp_pending   = phase_nxt == hrbe_pkg::PH_RESPOND;
    result.parser_phase   = phase_nxt;
    result.body_remaining = len_nxt[7:0];
  end

endmodule
`default_nettype wire

@@ rtl/hrbe_obuf.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP request body extractor output buffer
// Output register with a skid entry so that input ready is a register.
// ----------------------------------------------------------------------------
module hrbe_obuf (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  wire hrbe_pkg::result_t in_data,
  output logic                 in_ready,
  output logic                 out_valid,
  output hrbe_pkg::result_t    out_data,
  input  wire                  out_ready
);

  logic              out_v_r;
  logic              skid_v_r;
  hrbe_pkg::result_t out_d_r;
  hrbe_pkg::result_t skid_d_r;
  logic              take;
  logic              space;

  assign in_ready  = !skid_v_r;
  assign take      = in_valid && !skid_v_r;
  assign space     = !out_v_r || out_ready;
  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (space) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (space) begin
      out_v_r <= take;
    end else if (take) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (space) begin
        out_d_r <= skid_d_r;
      end
    end else if (space) begin
      out_d_r <= in_data;
    end else if (take) begin
      skid_d_r <= in_data;
    end
  end

endmodule
`default_nettype wire

@@ rtl/http_request_body_extractor.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP request body extractor
// Follows an HTTP request beat by beat and forwards its body to a display.
// ----------------------------------------------------------------------------
// Usage:
// The in_ch channel carries one beat per event: a request byte (opcode data)
// or a connection event (established, closed, response sent). Every accepted
// beat yields exactly one result beat on out_ch, in order.
// A result beat reports whether a body byte is to be written to the display,
// whether the display is to be cleared (end of headers), whether a response
// is pending, the parser phase and the low byte of the remaining body length.
// The result of an accepted beat is registered, in the skid entry if out_ch
// stalls. Throughput is one beat per cycle while in_ch is ready; the whole
// parse step for a byte is a handful of compares and one small multiply-add
// by ten into the length counter, all in the cycle of acceptance.
// The output stage is a result register plus one skid entry, so in_ch stays
// ready while a result waits to be taken. If the receiver stalls for longer,
// the skid entry fills and in_ch.ready falls until out_ch drains.
// Synchronous reset returns the parser to idle with all counters clear and
// empties the output stage. LENGTH_BITS sets the width of the length counter.
// ----------------------------------------------------------------------------
module http_request_body_extractor #(
  parameter int LENGTH_BITS = 8
) (
  input  wire          clk,
  input  wire          rst_n,
  hrbe_in_if.sink      in_ch,
  hrbe_out_if.source   out_ch
);

  logic              in_accept;
  logic              buf_ready;
  hrbe_pkg::result_t step_res;
  hrbe_pkg::result_t out_res;

  // A beat is taken whenever the skid entry of the output stage is free.
  assign in_ch.ready = buf_ready;
  assign in_accept   = in_ch.valid && buf_ready;

  // Parser state and the combinational step for the current beat.
  hrbe_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .opcode    (in_ch.opcode),
    .data_byte (in_ch.data_byte),
    .result    (step_res)
  );

  // Result register with skid entry.
  hrbe_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_data   (step_res),
    .in_ready  (buf_ready),
    .out_valid (out_ch.valid),
    .out_data  (out_res),
    .out_ready (out_ch.ready)
  );

  assign out_ch.lcd_write      = out_res.lcd_write;
  assign out_ch.lcd_data       = out_res.lcd_data;
  assign out_ch.screen_clear   = out_res.screen_clear;
  assign out_ch.resp_pending   = out_res.resp_pending;
  assign out_ch.parser_phase   = out_res.parser_phase;
  assign out_ch.body_remaining = out_res.body_remaining;

endmodule
`default_nettype wire
